// File: rtl/slt_pkg.sv
package slt_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned IdW    = 31;
  localparam int unsigned KindW  = 3;
  localparam int unsigned StatW  = 3;
  localparam int unsigned PosW   = 9;
  localparam int unsigned IndexW = 8;

  localparam logic [KindW-1:0] KindClear   = 3'd0;
  localparam logic [KindW-1:0] KindInsert  = 3'd1;
  localparam logic [KindW-1:0] KindLocate  = 3'd2;
  localparam logic [KindW-1:0] KindRead    = 3'd3;
  localparam logic [KindW-1:0] KindSetNext = 3'd4;

  localparam logic [StatW-1:0] StatOk       = 3'd0;
  localparam logic [StatW-1:0] StatNotFound = 3'd1;
  localparam logic [StatW-1:0] StatFull     = 3'd2;
  localparam logic [StatW-1:0] StatInvalid  = 3'd3;
  localparam logic [StatW-1:0] StatEmpty    = 3'd4;

  typedef struct packed {
    logic [KindW-1:0]         kind;
    logic signed [KeyW-1:0]   key;
    logic [IdW-1:0]           page_id;
    logic [IdW-1:0]           slot_id;
    logic [IndexW-1:0]        entry_index;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0]         status;
    logic [PosW-1:0]          position;
    logic signed [KeyW-1:0]   entry_key;
    logic [IdW-1:0]           entry_page;
    logic [IdW-1:0]           entry_slot;
    logic [PosW-1:0]          entry_count;
    logic signed [KeyW-1:0]   next_node;
  } rsp_t;

  typedef struct packed {
    logic signed [KeyW-1:0]   key;
    logic [IdW-1:0]           page;
    logic [IdW-1:0]           slot;
  } entry_t;

  typedef struct packed {
    logic pass_le;
    logic pass_lt;
    logic eq;
  } cmp_t;

endpackage

// File: rtl/slt_cell.sv
module slt_cell (
  input  logic            clk_i,
  input  logic            valid_i,
  input  logic            shift_en_i,
  input  logic            prev_pass_i,
  input  slt_pkg::entry_t prev_entry_i,
  input  slt_pkg::entry_t new_entry_i,
  output slt_pkg::entry_t entry_o,
  output slt_pkg::cmp_t   cmp_o
);

  slt_pkg::entry_t entry_q;
  slt_pkg::entry_t entry_d;
  logic            lt;
  logic            eq;

  always_comb begin
    lt = $signed(entry_q.key) < $signed(new_entry_i.key);
    eq = entry_q.key == new_entry_i.key;
    cmp_o.pass_lt = valid_i & lt;
    cmp_o.pass_le = valid_i & (lt | eq);
    cmp_o.eq      = valid_i & eq;
  end

  // An entry moves up one place when the new key sorts before it.
  always_comb begin
    entry_d = entry_q;
    if (shift_en_i && !cmp_o.pass_le) begin
      entry_d = prev_pass_i ? new_entry_i : prev_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: rtl/slt_pos_enc.sv
module slt_pos_enc #(
  parameter int unsigned N  = 65,
  parameter int unsigned PW = 9
) (
  input  logic [N-1:0]  onehot_i,
  output logic [PW-1:0] pos_o
);

  always_comb begin
    pos_o = '0;
    for (int i = 0; i < N; i++) begin
      pos_o = pos_o | (onehot_i[i] ? PW'(i) : '0);
    end
  end

endmodule

// File: rtl/sorted_leaf_table_unit.sv
// Sorted leaf table: a row of DEPTH cells keeps entries in ascending signed key order.
// A request is taken when start is high and busy is low; busy then stays high through the
// execute and respond states, and the result appears on rsp_o with done_o high for exactly one
// cycle once busy has fallen, with no way for the receiver to hold it off. The next request
// can be taken in that same cycle, so requests never overlap. The steps, in order: all cells
// compare and shift in parallel, the position is encoded from the registered compare row,
// and the result is registered onto the ports.
module sorted_leaf_table_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  slt_pkg::req_t req_i,
  output logic          done_o,
  output slt_pkg::rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StResp
  } state_e;

  state_e                        state_q;
  slt_pkg::req_t                 req_q;
  logic [CW-1:0]                 count_q;
  logic signed [slt_pkg::KeyW-1:0] next_q;
  logic [DEPTH-1:0]              pass_q;
  logic                          found_q;
  logic                          full_q;
  slt_pkg::entry_t               rd_q;
  logic                          done_q;
  slt_pkg::rsp_t                 rsp_q;
  slt_pkg::rsp_t                 rsp_d;

  slt_pkg::entry_t               new_entry;
  slt_pkg::entry_t               cell_entry [DEPTH];
  slt_pkg::cmp_t                 cell_cmp [DEPTH];
  logic [DEPTH-1:0]              pass_le;
  logic [DEPTH-1:0]              pass_lt;
  logic [DEPTH-1:0]              hit;
  logic                          full;
  logic                          ins_en;
  logic [DEPTH:0]                edge_vec;
  logic [slt_pkg::PosW-1:0]      pos;
  logic [slt_pkg::PosW-1:0]      idx_ext;
  logic [slt_pkg::PosW-1:0]      count_ext;

  assign new_entry.key  = req_q.key;
  assign new_entry.page = req_q.page_id;
  assign new_entry.slot = req_q.slot_id;

  assign full   = count_q == CW'(DEPTH);
  assign ins_en = (state_q == StExec) && (req_q.kind == slt_pkg::KindInsert) && !full;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            prev_pass;
    slt_pkg::entry_t prev_entry;

    if (i == 0) begin : g_first
      assign prev_pass  = 1'b1;
      assign prev_entry = new_entry;
    end else begin : g_rest
      assign prev_pass  = pass_le[i-1];
      assign prev_entry = cell_entry[i-1];
    end

    slt_cell u_cell (
      .clk_i        (clk_i),
      .valid_i      (CW'(i) < count_q),
      .shift_en_i   (ins_en),
      .prev_pass_i  (prev_pass),
      .prev_entry_i (prev_entry),
      .new_entry_i  (new_entry),
      .entry_o      (cell_entry[i]),
      .cmp_o        (cell_cmp[i])
    );

    assign pass_le[i] = cell_cmp[i].pass_le;
    assign pass_lt[i] = cell_cmp[i].pass_lt;
    assign hit[i]     = cell_cmp[i].eq;
  end

  // The pass row is a prefix of ones, so its boundary is one-hot.
  always_comb begin
    edge_vec[0] = !pass_q[0];
    for (int i = 1; i < DEPTH; i++) begin
      edge_vec[i] = pass_q[i-1] & !pass_q[i];
    end
    edge_vec[DEPTH] = pass_q[DEPTH-1];
  end

  slt_pos_enc #(
    .N  (DEPTH + 1),
    .PW (slt_pkg::PosW)
  ) u_pos_enc (
    .onehot_i (edge_vec),
    .pos_o    (pos)
  );

  assign idx_ext   = slt_pkg::PosW'(req_q.entry_index);
  assign count_ext = slt_pkg::PosW'(count_q);

  always_comb begin
    rsp_d             = '0;
    rsp_d.entry_count = count_ext;
    rsp_d.next_node   = next_q;
    unique case (req_q.kind)
      slt_pkg::KindInsert: begin
        if (full_q) begin
          rsp_d.status = slt_pkg::StatFull;
        end else begin
          rsp_d.position = pos;
        end
      end
      slt_pkg::KindLocate: begin
        rsp_d.position = pos;
        rsp_d.status   = found_q ? slt_pkg::StatOk : slt_pkg::StatNotFound;
      end
      slt_pkg::KindRead: begin
        if (idx_ext >= slt_pkg::PosW'(DEPTH)) begin
          rsp_d.status = slt_pkg::StatInvalid;
        end else if (idx_ext >= count_ext) begin
          rsp_d.status = slt_pkg::StatEmpty;
        end else begin
          rsp_d.entry_key  = rd_q.key;
          rsp_d.entry_page = rd_q.page;
          rsp_d.entry_slot = rd_q.slot;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      req_q   <= '0;
      count_q <= '0;
      next_q  <= '1;
      pass_q  <= '0;
      found_q <= 1'b0;
      full_q  <= 1'b0;
      rd_q    <= '0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      done_q <= state_q == StResp;
      unique case (state_q)
        StIdle: begin
          if (start) begin
            req_q   <= req_i;
            state_q <= StExec;
          end
        end
        StExec: begin
          pass_q  <= (req_q.kind == slt_pkg::KindInsert) ? pass_le : pass_lt;
          found_q <= |hit;
          full_q  <= full;
          rd_q    <= cell_entry[req_q.entry_index[IW-1:0]];
          if (req_q.kind == slt_pkg::KindClear) begin
            count_q <= '0;
          end else if (ins_en) begin
            count_q <= count_q + CW'(1);
          end
          if (req_q.kind == slt_pkg::KindSetNext) begin
            next_q <= {1'b0, req_q.page_id};
          end
          state_q <= StResp;
        end
        StResp: begin
          rsp_q   <= rsp_d;
          state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy   = state_q != StIdle;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !done_o) else $error("request accepted without going busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) && !busy) else $error("result without a request in flight");
  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held for two cycles");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH)) else $error("entry count beyond table depth");
`endif

endmodule
